// ----- design/pwmtim_pkg.sv -----
package pwmtim_pkg;

  // Field widths
  localparam int CLK_W      = 28;
  localparam int FREQ_W     = 16;
  localparam int PRESC_W    = 16;
  localparam int PERIOD_W   = 16;
  localparam int COMPARE_W  = 15;
  localparam int SPAN_SHIFT = 16;
  localparam int DIVHI_W    = CLK_W - SPAN_SHIFT;

  // Constants
  localparam logic [CLK_W-1:0]   CLOCK_RESET_HZ  = CLK_W'(16000000);
  localparam logic [PRESC_W-1:0] HIGH_BYTE_LIMIT = PRESC_W'(8'hFF);
  localparam logic [PRESC_W-1:0] SLOWEST_SETTING = {PRESC_W{1'b1}};

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture request, start first division
    logic step;    // one restoring division step
    logic load2;   // set up second division
    logic commit;  // write result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic freq_zero;
  } dp_stat_t;

endpackage

// ----- design/pwmtim_ctrl.sv -----
module pwmtim_ctrl
  import pwmtim_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam int CNT_W = $clog2(CLK_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CLK_W - 1);

  typedef enum logic [2:0] {IDLE, DIV1, LOAD2, DIV2, WRITE} state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  assign s_tready = (state == IDLE);

  // Command decode
  always_comb begin
    cmd.load   = (state == IDLE) && s_tvalid;
    cmd.step   = ((state == DIV1) && !stat.freq_zero) || (state == DIV2);
    cmd.load2  = (state == LOAD2);
    cmd.commit = (state == WRITE) && (!m_tvalid || m_tready);
  end

  // State, step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            state <= DIV1;
            cnt   <= '0;
          end
        end
        DIV1: begin
          if (stat.freq_zero) begin
            state <= WRITE;
          end else if (cnt == LAST_STEP) begin
            state <= LOAD2;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        LOAD2: begin
          state <= DIV2;
        end
        DIV2: begin
          if (cnt == LAST_STEP) begin
            state <= WRITE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        WRITE: begin
          if (!m_tvalid || m_tready) state <= IDLE;
        end
        default: state <= IDLE;
      endcase

      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/pwmtim_dpath.sv -----
module pwmtim_dpath
  import pwmtim_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CLK_W-1:0]     cfg_data,
  input  logic [FREQ_W-1:0]    req_frequency,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic [PRESC_W-1:0]   prescaler_value,
  output logic [PERIOD_W-1:0]  period_count,
  output logic [COMPARE_W-1:0] compare_count,
  output logic                 compare_written,
  output logic                 update_event
);

  logic [CLK_W-1:0]   osc_clock_hz;
  logic [PRESC_W-1:0] last_prescaler;

  // Shared restoring divider: q shifts dividend out, quotient in
  logic [CLK_W-1:0]  q;
  logic [FREQ_W-1:0] d;
  logic [FREQ_W-1:0] r;
  logic              freq_zero;
  logic              event_pend;

  logic [FREQ_W:0]    trial;
  logic [FREQ_W:0]    diff;
  logic               fits;
  logic [PRESC_W-1:0] presc_next;

  assign trial = {r, q[CLK_W-1]};
  assign diff  = trial - {1'b0, d};
  assign fits  = (trial >= {1'b0, d});

  // d holds divisor = prescaler + 1 after the second division
  assign presc_next = freq_zero ? SLOWEST_SETTING : (d - 1'b1);

  assign stat.freq_zero = freq_zero;

  // Clock register and stored prescaler
  always_ff @(posedge clk) begin
    if (rst) begin
      osc_clock_hz   <= CLOCK_RESET_HZ;
      last_prescaler <= '0;
    end else begin
      if (cfg_we) osc_clock_hz <= cfg_data;
      if (cmd.commit) last_prescaler <= presc_next;
    end
  end

  // Divider and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q          <= osc_clock_hz;
      d          <= req_frequency;
      r          <= '0;
      freq_zero  <= (req_frequency == '0);
      event_pend <= (req_frequency != '0) && (last_prescaler > HIGH_BYTE_LIMIT);
    end else if (cmd.load2) begin
      // divisor = div / 65536 + 1
      d <= {{(FREQ_W-DIVHI_W){1'b0}}, q[CLK_W-1 -: DIVHI_W]} + 1'b1;
      r <= '0;
    end else if (cmd.step) begin
      r <= fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
      q <= {q[CLK_W-2:0], fits};
    end

    if (cmd.commit) begin
      prescaler_value <= presc_next;
      if (freq_zero) begin
        period_count    <= SLOWEST_SETTING;
        compare_count   <= '0;
        compare_written <= 1'b0;
        update_event    <= 1'b0;
      end else begin
        period_count    <= q[PERIOD_W-1:0];
        compare_count   <= q[PERIOD_W-1:1];
        compare_written <= 1'b1;
        update_event    <= event_pend;
      end
    end
  end

endmodule

// ----- design/pwm_frequency_to_timer_settings_top.sv -----
// A nonzero frequency takes two 28-step passes of one shared restoring
// divider plus setup and write; frequency zero goes straight to the write.
// One item at a time: a finished result may wait in the output register
// while the next item is taken, and the write step stalls until that result
// is taken.
// Reset: clock register 16000000, stored prescaler 0, no result pending.
module pwm_frequency_to_timer_settings_top
  import pwmtim_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [27:0] cfg_data,     // osc_clock_hz
  // Request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,      // [15:0] req_frequency
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,      // [15:0] prescaler_value, [31:16] period_count,
                                    // [46:32] compare_count, [47] zero
  output logic [1:0]  m_tuser       // [0] compare_written, [1] update_event
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [PRESC_W-1:0]   prescaler_value;
  logic [PERIOD_W-1:0]  period_count;
  logic [COMPARE_W-1:0] compare_count;
  logic                 compare_written;
  logic                 update_event;

  assign cfg_ready = 1'b1;

  pwmtim_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pwmtim_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .req_frequency   (s_tdata),
    .cmd             (cmd),
    .stat            (stat),
    .prescaler_value (prescaler_value),
    .period_count    (period_count),
    .compare_count   (compare_count),
    .compare_written (compare_written),
    .update_event    (update_event)
  );

  assign m_tdata = {1'b0, compare_count, period_count, prescaler_value};
  assign m_tuser = {update_event, compare_written};

  // When written, the compare value is the period halved
  a_compare_half: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[46:32] == m_tdata[31:17])
    else $error("compare_count is not period_count / 2");

  // Zero request gives the slowest setting and no event
  a_zero_setting: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |->
      m_tdata[15:0] == 16'hFFFF && m_tdata[31:16] == 16'hFFFF && !m_tuser[1])
    else $error("zero request result wrong");

  // A 28-bit clock bounds the prescaler below 4096
  a_presc_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[15:12] == 4'h0)
    else $error("prescaler out of range");

  // No request is taken while the divider is busy
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !s_tready)
    else $error("request accepted during division");

endmodule

// ----- tb/pwm_timer_checker.sv -----
`timescale 1ns / 100ps

// Watches the configuration, request and result channels of the PWM timer
// block, predicts timer settings for each accepted request and compares.
module pwm_timer_checker
  import pwmtim_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [27:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic [1:0]  m_tuser,
  output int          errors,
  output int          pending,
  output int          results_seen,
  output int          events_seen
);

  typedef struct packed {
    logic [PRESC_W-1:0]   presc;
    logic [PERIOD_W-1:0]  period;
    logic [COMPARE_W-1:0] compare;
    logic                 pad;
    logic                 written;
    logic                 upd_evt;
  } timer_settings_t;

  // Predictor state: shadow of the clock register and the stored prescaler
  logic [CLK_W-1:0]   osc_hz;
  logic [PRESC_W-1:0] last_presc;
  timer_settings_t    settings_due[$];

  initial begin
    errors       = 0;
    pending      = 0;
    results_seen = 0;
    events_seen  = 0;
  end

  // Timer settings for one requested frequency; updates the stored prescaler
  function automatic timer_settings_t predict_timer_settings(input logic [FREQ_W-1:0] freq);
    timer_settings_t    ts;
    logic [CLK_W-1:0]   quo;
    logic [CLK_W-1:0]   divisor;
    logic [CLK_W-1:0]   period;
    ts = '0;
    if (freq == '0) begin
      ts.presc  = SLOWEST_SETTING;
      ts.period = {PERIOD_W{1'b1}};
    end else begin
      ts.upd_evt = (last_presc > HIGH_BYTE_LIMIT);
      quo        = osc_hz / CLK_W'(freq);
      divisor    = (quo >> SPAN_SHIFT) + 1'b1;
      period     = quo / divisor;
      ts.presc   = PRESC_W'(divisor - 1'b1);
      ts.period  = PERIOD_W'(period);
      ts.compare = COMPARE_W'(period >> 1);
      ts.written = 1'b1;
    end
    last_presc = ts.presc;
    return ts;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    if (errors < 40)
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got_v, want_v);
    errors++;
  endtask

  // Track transactions on all three channels
  always @(posedge clk) begin : watch
    timer_settings_t got;
    timer_settings_t want;
    if (rst) begin
      osc_hz     = CLOCK_RESET_HZ;
      last_presc = '0;
      settings_due.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        osc_hz = cfg_data;
      if (s_tvalid && s_tready)
        settings_due.push_back(predict_timer_settings(s_tdata));
      if (m_tvalid && m_tready) begin
        got.presc   = m_tdata[15:0];
        got.period  = m_tdata[31:16];
        got.compare = m_tdata[46:32];
        got.pad     = m_tdata[47];
        got.written = m_tuser[0];
        got.upd_evt = m_tuser[1];
        results_seen++;
        if (got.upd_evt)
          events_seen++;
        if (settings_due.size() == 0) begin
          report_mismatch("result with nothing expected", m_tdata[31:0], '0);
        end else begin
          want = settings_due.pop_front();
          if (got.presc !== want.presc)
            report_mismatch("prescaler_value", 32'(got.presc), 32'(want.presc));
          if (got.period !== want.period)
            report_mismatch("period_count", 32'(got.period), 32'(want.period));
          if (got.compare !== want.compare)
            report_mismatch("compare_count", 32'(got.compare), 32'(want.compare));
          if (got.pad !== want.pad)
            report_mismatch("tdata padding bit", 32'(got.pad), 32'(want.pad));
          if (got.written !== want.written)
            report_mismatch("compare_written", 32'(got.written), 32'(want.written));
          if (got.upd_evt !== want.upd_evt)
            report_mismatch("update_event", 32'(got.upd_evt), 32'(want.upd_evt));
        end
      end
    end
    pending <= settings_due.size();
  end

endmodule

// ----- tb/pwm_frequency_to_timer_settings_top_tb.sv -----
`timescale 1ns / 100ps

module pwm_frequency_to_timer_settings_top_tb
  import pwmtim_pkg::*;
();

  localparam int CYCLE_LIMIT  = 1500000;
  localparam int TAIL_CYCLES  = 64;
  localparam int PHASE_ITEMS  = 145;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CLK_W-1:0]  cfg_data  = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [FREQ_W-1:0] s_tdata   = '0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [47:0]       m_tdata;
  logic [1:0]        m_tuser;

  int errors, pending, results_seen, events_seen;
  int cyc_cnt    = 0;
  int n_items    = 0;
  int n_settings = 0;
  int burst_left = 0;
  bit no_idle    = 1'b0;
  logic [CLK_W-1:0] cur_hz = CLOCK_RESET_HZ;

  rx_mode_t rx_mode   = RX_ALWAYS;
  int       mode_left = 0;

  pwm_frequency_to_timer_settings_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  pwm_timer_checker chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen),
    .events_seen  (events_seen)
  );

  always #1 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cyc_cnt, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side backpressure: four random modes, redrawn when each mode's countdown runs out
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(100, 600);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_ALWAYS:  m_tready <= 1'b1;
        RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
        RX_PATTERN: m_tready <= (cyc_cnt % 7) < 2;
        default:    m_tready <= ($urandom_range(0, 40) == 0);
      endcase
    end
  end

  // One request transaction, with burst gaps ahead of it
  task automatic send_freq(input logic [FREQ_W-1:0] f);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_idle ? 0 : $urandom_range(0, 70);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= f;
    do @(posedge clk); while (!s_tready);
    n_items++;
  endtask

  // Hold off the request side until every expected result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_clock(input logic [CLK_W-1:0] hz);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= hz;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_hz = hz;
    n_settings++;
  endtask

  // Random request, biased toward zero, small values, bit corners and the
  // frequencies where the prescaler steps up
  function automatic logic [FREQ_W-1:0] pick_freq(input logic [CLK_W-1:0] hz);
    int unsigned sel;
    int unsigned k;
    int unsigned f;
    sel = $urandom_range(0, 99);
    if (sel < 8)
      return '0;
    if (sel < 20)
      return FREQ_W'($urandom_range(1, 16));
    if (sel < 38 && hz >= 28'h10000) begin
      k = $urandom_range(1, hz >> SPAN_SHIFT);
      f = hz / (k << SPAN_SHIFT) + $urandom_range(0, 2);
      f = (f > 1) ? f - 1 : 1;
      return (f > 65535) ? 16'hFFFF : FREQ_W'(f);
    end
    if (sel < 52)
      return FREQ_W'($urandom_range(0, 65535) >> $urandom_range(0, 15));
    if (sel < 58)
      return (sel[0]) ? 16'hFFFF : 16'h0001;
    return FREQ_W'($urandom_range(0, 65535));
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_freq(pick_freq(cur_hz));
      // at random, pause once mid-phase until the pipeline is empty
      if (i == count / 2 && $urandom_range(0, 2) == 0)
        wait_drained();
    end
  endtask

  initial begin
    logic [CLK_W-1:0] hz;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset clock; zero requests, event after slowest setting,
    // bit corners, the divisor step near 244 Hz
    no_idle = 1'b1;
    send_freq(16'd0);
    send_freq(16'd1);
    send_freq(16'hFFFF);
    send_freq(16'h5555);
    send_freq(16'hAAAA);
    send_freq(16'h8000);
    send_freq(16'd244);
    send_freq(16'd245);
    send_freq(16'd2);
    send_freq(16'd0);
    send_freq(16'd0);
    send_freq(16'd7);

    // Directed: largest clock, largest divisor, prescaler around 255
    no_idle = 1'b0;
    write_clock({CLK_W{1'b1}});
    send_freq(16'd1);
    send_freq(16'd1);
    send_freq(16'd15);
    send_freq(16'd16);
    send_freq(16'd16);
    send_freq(16'hFFFF);
    send_freq(16'd0);

    // Directed: smallest clock, clock below frequency
    write_clock(28'd1);
    send_freq(16'd1);
    send_freq(16'd2);
    send_freq(16'hFFFF);
    send_freq(16'd0);

    // Random phases over a range of clock settings
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0:       hz = CLOCK_RESET_HZ;
        1:       hz = {CLK_W{1'b1}};
        2:       hz = 28'd1;
        3:       hz = CLK_W'($urandom_range(1, 1000));
        4:       hz = CLK_W'($urandom_range(32768, 200000));
        5:       hz = 28'd72000000;
        default: hz = CLK_W'($urandom_range(1, 28'hFFFFFFF));
      endcase
      no_idle = (ph % 3 == 1);
      write_clock(hz);
      run_random(PHASE_ITEMS);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d frequency requests over %0d clock settings plus reset value",
             n_items, n_settings);
    $display("Checked %0d results, %0d of them with an update event",
             results_seen, events_seen);
    if (errors == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sim.f -----
design/pwmtim_pkg.sv
design/pwmtim_ctrl.sv
design/pwmtim_dpath.sv
design/pwm_frequency_to_timer_settings_top.sv
tb/pwm_timer_checker.sv
tb/pwm_frequency_to_timer_settings_top_tb.sv
